### rtl/tcsp_pkg.sv
// Shared types, codes and constants for the three-channel servo PWM block.
`default_nettype none

package tcsp_pkg;

   localparam int CNT_BITS_DEF = 12;
   localparam int CFG_BITS     = 12;
   localparam int SAMPLE_BITS  = 10;
   localparam int NUM_CH       = 3;
   localparam int CH_BITS      = 2;
   localparam int PROD_BITS    = SAMPLE_BITS + CFG_BITS;

   localparam logic [CFG_BITS-1:0]    PERIOD_RESET = 12'd1806;
   localparam logic [CFG_BITS-1:0]    PMAX_RESET   = 12'd225;
   localparam logic [CFG_BITS-1:0]    PSPAN_RESET  = 12'd180;
   localparam logic [CFG_BITS-1:0]    WIDTH_RESET  = 12'd45;
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE   = 10'd1023;
   localparam logic [CH_BITS-1:0]     LAST_CH      = 2'd2;

   // opcode values
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // register indexes
   localparam logic [1:0] CSR_PERIOD = 2'd0;
   localparam logic [1:0] CSR_PMAX   = 2'd1;
   localparam logic [1:0] CSR_PSPAN  = 2'd2;

   typedef struct packed {
      logic                   opcode;
      logic [SAMPLE_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic [CH_BITS-1:0] channel_select;
      logic               start_conversion;
      logic [NUM_CH-1:0]  levels;   // bit 0 = servo one
   } result_type;

endpackage

`default_nettype wire

### rtl/three_channel_servo_pwm.sv
// An accepted request word passes the input register, then the result register, to its response word.
// Throughput: one word per cycle while the response side does not stall; the width update runs
// in the same cycle as the third sample, through three constant-divide width units.
// Reset (synchronous, active high): counter, channel, samples and levels
// clear, pulse widths load 45, registers load their default values.
`default_nettype none

module three_channel_servo_pwm
   import tcsp_pkg::*;
#(
   parameter int COUNT_BITS = CNT_BITS_DEF
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_addr,
   input  wire logic [CFG_BITS-1:0] csr_wdata,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [15:0]         req_tdata,   // [9:0] sample, rest zero
   input  wire logic                req_tuser,   // [0] opcode
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata    // [0] servo_one_level,
                                                 // [1] servo_two_level,
                                                 // [2] servo_three_level,
                                                 // [3] start_conversion,
                                                 // [5:4] channel_select
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   result_type rsp_word;

   assign req_item.opcode = req_tuser;
   assign req_item.sample = req_tdata[SAMPLE_BITS-1:0];

   tcsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tcsp_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {2'b00, rsp_word.channel_select, rsp_word.start_conversion,
                       rsp_word.levels};

endmodule

`default_nettype wire

### rtl/tcsp_in_reg.sv
// Input register for the request channel.
`default_nettype none

module tcsp_in_reg
   import tcsp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire item_type req_item,
   input  wire logic     advance,
   output logic          item_valid,
   output item_type      item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // take a new word when empty or when the held one moves on
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         if (req_tvalid) begin
            item_in = req_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

### rtl/tcsp_width_calc.sv
// Pulse width from one sample: max - sample*span/1023, floored at zero.
`default_nettype none

module tcsp_width_calc
   import tcsp_pkg::*;
(
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [CFG_BITS-1:0]    pulse_span,
   input  wire logic [CFG_BITS-1:0]    pulse_max,
   output logic      [CFG_BITS-1:0]    width
);

   localparam int EST_BITS = PROD_BITS + 1;
   localparam int Q_BITS   = EST_BITS - SAMPLE_BITS;

   logic [PROD_BITS-1:0] prod;
   logic [EST_BITS-1:0]  est_sum;
   logic [Q_BITS-1:0]    q_est;
   logic [EST_BITS-1:0]  rem;
   logic [Q_BITS-1:0]    drop_full;
   logic [CFG_BITS-1:0]  drop;

   always_comb begin
      prod    = PROD_BITS'(sample) * PROD_BITS'(pulse_span);
      // x/1023 ~ (x + x/1024)/1024, low by at most one
      est_sum = EST_BITS'(prod) + EST_BITS'(prod >> SAMPLE_BITS);
      q_est   = Q_BITS'(est_sum >> SAMPLE_BITS);
      // remainder = x - 1023*q = x - 1024*q + q
      rem     = EST_BITS'(prod) - (EST_BITS'(q_est) << SAMPLE_BITS) + EST_BITS'(q_est);
      drop_full = (rem >= EST_BITS'(FULL_SCALE)) ? q_est + Q_BITS'(1) : q_est;
      drop    = CFG_BITS'(drop_full);
      width   = (drop > pulse_max) ? '0 : pulse_max - drop;
   end

endmodule

`default_nettype wire

### rtl/tcsp_core.sv
// Period counter, sample store, width update and result register.
`default_nettype none

module tcsp_core
   import tcsp_pkg::*;
#(
   parameter int COUNT_BITS = CNT_BITS_DEF
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_addr,
   input  wire logic [CFG_BITS-1:0] csr_wdata,
   input  wire logic                item_valid,
   input  wire item_type            item,
   output logic                     advance,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output result_type               rsp_word
);

   localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   logic [CFG_BITS-1:0]    period_ff, period_in;
   logic [CFG_BITS-1:0]    pmax_ff, pmax_in;
   logic [CFG_BITS-1:0]    pspan_ff, pspan_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [CH_BITS-1:0]     chan_ff, chan_in;
   logic [SAMPLE_BITS-1:0] samples_ff [NUM_CH];
   logic [SAMPLE_BITS-1:0] samples_in [NUM_CH];
   logic [CFG_BITS-1:0]    widths_ff  [NUM_CH];
   logic [CFG_BITS-1:0]    widths_in  [NUM_CH];
   logic [NUM_CH-1:0]      levels_ff, levels_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   logic [SAMPLE_BITS-1:0] calc_sample [NUM_CH];
   logic [CFG_BITS-1:0]    calc_width  [NUM_CH];
   logic [COUNT_BITS-1:0]  count_inc;
   logic                   wrap;

   assign advance = item_valid && (!rsp_valid_ff || rsp_tready);

   // the sample being delivered replaces the stored one of its channel
   for (genvar k = 0; k < NUM_CH; k++) begin : g_calc
      assign calc_sample[k] = (chan_ff == CH_BITS'(k)) ? item.sample : samples_ff[k];
      tcsp_width_calc u_width (
         .sample     (calc_sample[k]),
         .pulse_span (pspan_ff),
         .pulse_max  (pmax_ff),
         .width      (calc_width[k])
      );
   end

   always_comb begin
      period_in = period_ff;
      pmax_in   = pmax_ff;
      pspan_in  = pspan_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_PERIOD: period_in = csr_wdata;
            CSR_PMAX:   pmax_in   = csr_wdata;
            CSR_PSPAN:  pspan_in  = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_comb begin
      count_inc  = count_ff + COUNT_BITS'(1);
      wrap       = CMP_BITS'(count_inc) >= CMP_BITS'(period_ff);
      count_in   = count_ff;
      chan_in    = chan_ff;
      samples_in = samples_ff;
      widths_in  = widths_ff;
      levels_in  = levels_ff;
      rsp_in     = rsp_ff;

      if (advance) begin
         rsp_in.start_conversion = 1'b0;
         if (item.opcode == OP_TICK) begin
            count_in = wrap ? '0 : count_inc;
            for (int k = 0; k < NUM_CH; k++) begin
               levels_in[k] = CMP_BITS'(count_in) < CMP_BITS'(widths_ff[k]);
            end
            rsp_in.start_conversion = wrap;
         end else begin
            for (int k = 0; k < NUM_CH; k++) begin
               samples_in[k] = calc_sample[k];
            end
            if (chan_ff >= LAST_CH) begin
               chan_in   = '0;
               widths_in = calc_width;
            end else begin
               chan_in = chan_ff + CH_BITS'(1);
            end
         end
         rsp_in.levels         = levels_in;
         rsp_in.channel_select = chan_in;
      end

      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         pmax_ff      <= PMAX_RESET;
         pspan_ff     <= PSPAN_RESET;
         count_ff     <= '0;
         chan_ff      <= '0;
         levels_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_CH; k++) begin
            samples_ff[k] <= '0;
            widths_ff[k]  <= WIDTH_RESET;
         end
      end else begin
         period_ff    <= period_in;
         pmax_ff      <= pmax_in;
         pspan_ff     <= pspan_in;
         count_ff     <= count_in;
         chan_ff      <= chan_in;
         levels_ff    <= levels_in;
         rsp_valid_ff <= rsp_valid_in;
         samples_ff   <= samples_in;
         widths_ff    <= widths_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule

`default_nettype wire

### test/three_channel_servo_pwm_tb.sv
// Self-checking testbench for the three-channel servo PWM block with its own predictor.
`default_nettype none

module three_channel_servo_pwm_tb
   import tcsp_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // Predicts the response word for every accepted request word and checks the stream.
   class servo_pwm_scoreboard;
      logic [CFG_BITS-1:0]     period_ticks;
      logic [CFG_BITS-1:0]     pulse_max;
      logic [CFG_BITS-1:0]     pulse_span;
      logic [CNT_BITS_DEF-1:0] tick_count;
      logic [CH_BITS-1:0]      channel;
      logic [SAMPLE_BITS-1:0]  samples[NUM_CH];
      logic [CFG_BITS-1:0]     widths[NUM_CH];
      logic [NUM_CH-1:0]       levels;
      result_type              expected_words[$];
      int                      errors;

      function new();
         period_ticks = PERIOD_RESET;
         pulse_max    = PMAX_RESET;
         pulse_span   = PSPAN_RESET;
         tick_count   = '0;
         channel      = '0;
         levels       = '0;
         errors       = 0;
         for (int k = 0; k < NUM_CH; k++) begin
            samples[k] = '0;
            widths[k]  = WIDTH_RESET;
         end
      endfunction

      function void write_reg(logic [1:0] index, logic [CFG_BITS-1:0] value);
         case (index)
            CSR_PERIOD: period_ticks = value;
            CSR_PMAX:   pulse_max    = value;
            CSR_PSPAN:  pulse_span   = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_request(logic opcode, logic [SAMPLE_BITS-1:0] sample);
         result_type  word;
         int unsigned drop;
         word.start_conversion = 1'b0;
         if (opcode == OP_TICK) begin
            tick_count = tick_count + 1'b1;
            if (tick_count >= period_ticks) begin
               tick_count = '0;
               word.start_conversion = 1'b1;
            end
            for (int k = 0; k < NUM_CH; k++)
               levels[k] = (tick_count < widths[k]);
         end else begin
            if (channel < NUM_CH)
               samples[channel] = sample;
            channel = channel + 1'b1;
            // third sample stored: reload all widths from the new readings
            if (channel >= NUM_CH) begin
               channel = '0;
               for (int k = 0; k < NUM_CH; k++) begin
                  drop = (int'(samples[k]) * int'(pulse_span)) / int'(FULL_SCALE);
                  widths[k] = (drop > pulse_max) ? '0 : CFG_BITS'(pulse_max - drop);
               end
            end
         end
         word.levels         = levels;
         word.channel_select = channel;
         expected_words.push_back(word);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(logic [7:0] data);
         result_type exp_word;
         result_type got;
         got = data[$bits(result_type)-1:0];
         if (expected_words.size() == 0) begin
            $error("response word 0x%02h with no request outstanding", data);
            errors++;
            return;
         end
         exp_word = expected_words.pop_front();
         compare_field("servo_one_level", int'(exp_word.levels[0]), int'(got.levels[0]));
         compare_field("servo_two_level", int'(exp_word.levels[1]), int'(got.levels[1]));
         compare_field("servo_three_level", int'(exp_word.levels[2]), int'(got.levels[2]));
         compare_field("start_conversion", int'(exp_word.start_conversion),
                       int'(got.start_conversion));
         compare_field("channel_select", int'(exp_word.channel_select),
                       int'(got.channel_select));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_addr = CSR_PERIOD;
   logic [CFG_BITS-1:0] csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;   // [9:0] sample, rest zero
   logic                req_tuser = OP_TICK;   // [0] opcode
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [7:0]          rsp_tdata;   // [0] servo one, [1] servo two, [2] servo three,
                                     // [3] start_conversion, [5:4] channel_select

   servo_pwm_scoreboard board = new();

   bit calm = 1'b0;     // no idling on either side
   int hold_req = 0;    // long receiver hold requested by the stimulus
   int hold_left = 0;
   int stall_left = 0;

   three_channel_servo_pwm dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   initial begin
      #400_000;
      $display("FAILED: results differ");
      $finish;
   end

   // receiver: long holds on request, short random stalls otherwise
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(5) == 0) begin
         stall_left = $urandom_range(4, 1) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata);
   end

   task automatic send_word(input logic opcode, input logic [SAMPLE_BITS-1:0] sample);
      int gap;
      if (!calm && $urandom_range(4) == 0) begin
         gap = $urandom_range(4, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= opcode;
      req_tdata  <= {{(16 - SAMPLE_BITS){1'b0}}, sample};
      do @(posedge clock); while (!req_tready);
      board.note_request(opcode, sample);
   endtask

   // drop valid and wait for every outstanding response word
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 2000 && board.pending() > 0; i++)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [CFG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_reg(index, value);
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [CFG_BITS-1:0] period,
                                 input logic [CFG_BITS-1:0] pmax,
                                 input logic [CFG_BITS-1:0] pspan);
      write_reg(CSR_PERIOD, period);
      write_reg(CSR_PMAX, pmax);
      write_reg(CSR_PSPAN, pspan);
   endtask

   // pick settings biased toward short frames so wraps and pulse edges show up often
   task automatic random_settings();
      logic [CFG_BITS-1:0] period;
      logic [CFG_BITS-1:0] pmax;
      logic [CFG_BITS-1:0] pspan;
      case ($urandom_range(5))
         0:       period = '0;
         1:       period = CFG_BITS'(1);
         2:       period = CFG_BITS'($urandom_range(4095, 1));
         default: period = CFG_BITS'($urandom_range(64, 2));
      endcase
      case ($urandom_range(5))
         0:       pmax = '0;
         1:       pmax = 12'hFFF;
         2:       pmax = CFG_BITS'($urandom_range(4095));
         default: pmax = CFG_BITS'($urandom_range(80));
      endcase
      case ($urandom_range(4))
         0:       pspan = '0;
         1:       pspan = 12'hFFF;
         default: pspan = CFG_BITS'($urandom_range(4095));
      endcase
      write_settings(period, pmax, pspan);
   endtask

   task automatic run_items(input int count, input int sample_pct);
      logic                   opcode;
      logic [SAMPLE_BITS-1:0] sample;
      for (int i = 0; i < count; i++) begin
         opcode = ($urandom_range(99) < sample_pct) ? OP_SAMPLE : OP_TICK;
         case ($urandom_range(7))
            0:       sample = '0;
            1:       sample = '1;
            default: sample = SAMPLE_BITS'($urandom_range(1023));
         endcase
         send_word(opcode, sample);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: widths still at their reset value, then a first reload
      send_word(OP_TICK, 10'd0);
      send_word(OP_TICK, 10'h3FF);
      send_word(OP_SAMPLE, 10'd0);
      send_word(OP_SAMPLE, 10'd1023);
      send_word(OP_SAMPLE, 10'd512);
      send_word(OP_TICK, 10'd0);
      send_word(OP_TICK, 10'd0);
      drain();

      // zero period wraps on every tick; large span pushes the drop past the maximum, so widths floor at zero
      write_settings(12'd0, 12'd0, 12'hFFF);
      send_word(OP_TICK, 10'd0);
      send_word(OP_TICK, 10'd0);
      send_word(OP_SAMPLE, 10'd1023);
      send_word(OP_SAMPLE, 10'd1023);
      send_word(OP_SAMPLE, 10'd1023);
      send_word(OP_TICK, 10'd0);
      send_word(OP_TICK, 10'd0);
      drain();

      write_settings(12'd2, 12'hFFF, 12'hFFF);
      send_word(OP_SAMPLE, 10'd0);
      send_word(OP_SAMPLE, 10'd1023);
      send_word(OP_SAMPLE, 10'd1);
      send_word(OP_TICK, 10'd0);
      send_word(OP_TICK, 10'd0);
      send_word(OP_TICK, 10'd0);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         random_settings();
         // hold the receiver long enough for the request side to back up
         if (phase == 5)
            hold_req = 300;
         run_items(45, 25);
         drain();
      end

      // long frame with full widths: all levels stay high
      calm = 1'b1;
      write_settings(12'hFFF, 12'hFFF, 12'd0);
      run_items(3, 100);
      run_items(40, 0);
      drain();

      random_settings();
      run_items(40, 25);
      drain();
      repeat (10) @(posedge clock);

      if (board.pending() > 0) begin
         $error("%0d response words never arrived", board.pending());
         board.errors++;
      end
      if (board.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire
